// ===== rtl/core/can_tx_frame_queue_macros.svh =====
// assertion helpers for the checker file
`ifndef CAN_TX_FRAME_QUEUE_MACROS_SVH
`define CAN_TX_FRAME_QUEUE_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define CTFQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define CTFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ctfq_pkg.sv =====
package ctfq_pkg;

  // default ring size
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // field widths
  localparam int unsigned ID_W       = 29;
  localparam int unsigned STD_ID_W   = 11;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned HDR_W      = ID_W + 1 + LEN_W;
  localparam int unsigned OVF_W      = 16;
  localparam int unsigned QUEUED_W   = 5;
  localparam int unsigned S_TDATA_W  = 104;
  localparam int unsigned M_TDATA_W  = 128;
  localparam int unsigned M_USED_W   = 123;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(8);
  localparam logic [OVF_W-1:0] OVF_MAX = '1;

  // command codes
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_SERVICE = 1'b1;

  // one request from the input side
  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]   frame_id;
    logic              extended_frame;
    logic [LEN_W-1:0]  frame_length;
    logic [DATA_W-1:0] frame_data;
    logic              tx_complete;
    logic              bus_off;
  } ctfq_item_t;

  // per-request result fields that do not come from the stores
  typedef struct packed {
    logic                accepted;
    logic                launch;
    logic                clear_complete;
    logic                reinit_request;
    logic [OVF_W-1:0]    overflow_total;
    logic [QUEUED_W-1:0] queued_frames;
  } ctfq_status_t;

  // mask that keeps the first len bytes, len already limited to eight
  function automatic logic [DATA_W-1:0] ctfq_byte_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      m[b*8 +: 8] = (LEN_W'(b) < len) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/ctfq_ram.sv =====
module ctfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/ctfq_ctrl.sv =====
module ctfq_ctrl import ctfq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ctfq_item_t         item_i,
  output logic               wr_en_o,
  output logic [ADDR_W-1:0]  wr_addr_o,
  output logic [HDR_W-1:0]   wr_header_o,
  output logic [DATA_W-1:0]  wr_payload_o,
  output logic               rd_en_o,
  output logic [ADDR_W-1:0]  rd_addr_o,
  output ctfq_status_t       status_o
);

  // pointers run modulo twice the depth so full and empty differ
  localparam int unsigned PTR_W = ADDR_W + 1;
  localparam int unsigned FILL_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] SPAN_F = FILL_W'(2 * QUEUE_DEPTH);

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OVF_W-1:0] ovf_cnt_q, ovf_cnt_d;
  logic             waiting_q, waiting_d;

  logic [PTR_W-1:0]  fill_now;
  logic [LEN_W-1:0]  len_sat;
  logic [ID_W-1:0]   id_cut;

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_fill(input logic [PTR_W-1:0] w,
                                                input logic [PTR_W-1:0] r);
    logic [FILL_W-1:0] f;
    f = (w >= r) ? {1'b0, w} - {1'b0, r} : {1'b0, w} + SPAN_F - {1'b0, r};
    return f[PTR_W-1:0];
  endfunction

  // frame clean-up before storing
  always_comb begin
    len_sat = (item_i.frame_length > LEN_MAX) ? LEN_MAX : item_i.frame_length;
    id_cut  = item_i.extended_frame ? item_i.frame_id
                                    : {{(ID_W-STD_ID_W){1'b0}}, item_i.frame_id[STD_ID_W-1:0]};
  end

  assign fill_now     = ptr_fill(wr_ptr_q, rd_ptr_q);
  assign wr_addr_o    = ptr_slot(wr_ptr_q);
  assign rd_addr_o    = ptr_slot(rd_ptr_q);
  assign wr_header_o  = {len_sat, item_i.extended_frame, id_cut};
  assign wr_payload_o = item_i.frame_data & ctfq_byte_mask(len_sat);

  // queue and sender update for one request
  always_comb begin
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    ovf_cnt_d = ovf_cnt_q;
    waiting_d = waiting_q;
    wr_en_o   = 1'b0;
    rd_en_o   = 1'b0;
    status_o  = '0;
    if (accept_i) begin
      unique case (item_i.cmd)
        CMD_ENQUEUE: begin
          if (fill_now >= DEPTH_P) begin
            // overflow: drop the frame and empty the ring
            if (ovf_cnt_q != OVF_MAX) begin
              ovf_cnt_d = ovf_cnt_q + OVF_W'(1);
            end
            rd_ptr_d = wr_ptr_q;
          end else begin
            wr_en_o           = 1'b1;
            wr_ptr_d          = ptr_advance(wr_ptr_q);
            status_o.accepted = 1'b1;
          end
        end
        CMD_SERVICE: begin
          if (!waiting_q) begin
            if (fill_now != '0) begin
              rd_en_o         = 1'b1;
              rd_ptr_d        = ptr_advance(rd_ptr_q);
              waiting_d       = 1'b1;
              status_o.launch = 1'b1;
            end
          end else if (item_i.tx_complete) begin
            waiting_d               = 1'b0;
            status_o.clear_complete = 1'b1;
          end
          status_o.reinit_request = item_i.bus_off;
        end
        default: begin
        end
      endcase
    end
    status_o.overflow_total = ovf_cnt_d;
    status_o.queued_frames  = QUEUED_W'(ptr_fill(wr_ptr_d, rd_ptr_d));
  end

  // queue state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      ovf_cnt_q <= '0;
      waiting_q <= 1'b0;
    end else begin
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      ovf_cnt_q <= ovf_cnt_d;
      waiting_q <= waiting_d;
    end
  end

endmodule

// ===== rtl/core/can_tx_frame_queue.sv =====
// Transmit queue for CAN frames in front of a controller.
// Input stream (s_axis): one request per transfer. tuser selects the kind:
// enqueue stores a frame in the ring, service ticks the two-state sender with
// the controller's completion and bus-off flags. Output stream (m_axis): one
// result per request, in request order, carrying the accept flag, a launched
// frame if any, the clear and reinit requests, the overflow count and the
// number of frames left queued.
// Throughput: one request per cycle while the receiver takes each result. The
// result is valid in the cycle after the input transfer, as the frame stores,
// which launch data leaves through, have a registered read port.
// Reset empties the ring, clears the overflow count and leaves the sender
// idle; the store contents are not cleared, and only written entries are read.
// While the receiver stalls, the finished result and the store read register
// hold, and the input keeps taking requests only in the cycle the pending
// result is taken.
module can_tx_frame_queue import ctfq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // frame_id[28:0], extended_frame[29], frame_length[33:30],
  // frame_data[97:34], tx_complete[98], bus_off[99], zero fill[103:100]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // cmd[0]
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // accepted[0], launch[1], launch_id[30:2], launch_extended[31],
  // launch_length[35:32], launch_data[99:36], clear_complete[100],
  // reinit_request[101], overflow_total[117:102], queued_frames[122:118],
  // zero fill[127:123]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  ctfq_item_t        item;
  ctfq_status_t      status;
  ctfq_status_t      status_q;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [HDR_W-1:0]  wr_header, rd_header, launch_header;
  logic [DATA_W-1:0] wr_payload, rd_payload, launch_payload;

  // request unpacking
  always_comb begin
    item.cmd            = s_axis_tuser[0];
    item.frame_id       = s_axis_tdata[28:0];
    item.extended_frame = s_axis_tdata[29];
    item.frame_length   = s_axis_tdata[33:30];
    item.frame_data     = s_axis_tdata[97:34];
    item.tx_complete    = s_axis_tdata[98];
    item.bus_off        = s_axis_tdata[99];
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ctfq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_header_o (wr_header),
    .wr_payload_o(wr_payload),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .status_o    (status)
  );

  // frame header store: id, format, length
  ctfq_ram #(
    .WIDTH(HDR_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_header_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_header),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_header)
  );

  // frame payload store
  ctfq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_payload_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_payload),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_payload)
  );

  // result register
  assign out_valid_d = accept ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status;
    end
  end

  // launch fields read as zero when nothing is launched
  assign launch_header  = status_q.launch ? rd_header : '0;
  assign launch_payload = status_q.launch ? rd_payload : '0;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    {(M_TDATA_W-M_USED_W){1'b0}},
    status_q.queued_frames,
    status_q.overflow_total,
    status_q.reinit_request,
    status_q.clear_complete,
    launch_payload,
    launch_header,
    status_q.launch,
    status_q.accepted
  };

endmodule

// ===== rtl/core/ctfq_checker.sv =====
`include "can_tx_frame_queue_macros.svh"

module ctfq_checker import ctfq_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic [0:0]           s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result stays up and unchanged
  `CTFQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // a pending untaken result blocks new requests
  `CTFQ_ASSERT_NOW(a_in_blocked, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "request taken while result stalled")

  // enqueue answers and sender actions never share one result
  `CTFQ_ASSERT_NOW(a_kind_excl, m_axis_tvalid, !(m_axis_tdata[0] && (m_axis_tdata[1] || m_axis_tdata[100] || m_axis_tdata[101])) && !(m_axis_tdata[1] && m_axis_tdata[100]), "mixed result kinds")

  // launch fields are zero without a launch
  `CTFQ_ASSERT_NOW(a_launch_zero, m_axis_tvalid && !m_axis_tdata[1], m_axis_tdata[99:2] == '0, "launch fields set without launch")

endmodule

bind can_tx_frame_queue ctfq_checker u_ctfq_checker (.*);

// ===== tb/sv/can_tx_frame_queue_tb.sv =====
`timescale 1ns / 100ps

module can_tx_frame_queue_tb;
  import ctfq_pkg::*;

  localparam int unsigned DEPTH        = QUEUE_DEPTH_DEF;
  localparam int unsigned SPAN         = 2 * DEPTH;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_REPORTS  = 10;

  // one result as the block reports it
  typedef struct packed {
    logic                accepted;
    logic                launch;
    logic [ID_W-1:0]     launch_id;
    logic                launch_extended;
    logic [LEN_W-1:0]    launch_length;
    logic [DATA_W-1:0]   launch_data;
    logic                clear_complete;
    logic                reinit_request;
    logic [OVF_W-1:0]    overflow_total;
    logic [QUEUED_W-1:0] queued_frames;
  } queue_result_t;

  // one line of the directed plan, optionally with a hand-written result
  typedef struct {
    ctfq_item_t    req;
    int unsigned   reps;
    bit            fixed;
    queue_result_t result;
  } stim_row_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_SPARSE,
    RX_BLOCKS
  } rx_mode_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = CMD_ENQUEUE;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  queue_result_t pending_results[$];
  int unsigned   error_count  = 0;
  int unsigned   result_count = 0;
  int unsigned   cycle_count  = 0;
  int unsigned   burst_left   = 0;
  int unsigned   rx_cycle     = 0;
  rx_mode_e      rx_mode      = RX_ALWAYS;

  // shadow copy of the ring and the sender
  logic [ID_W-1:0]   ring_id   [DEPTH];
  logic              ring_ext  [DEPTH];
  logic [LEN_W-1:0]  ring_len  [DEPTH];
  logic [DATA_W-1:0] ring_data [DEPTH];
  int unsigned       wr_ptr        = 0;
  int unsigned       rd_ptr        = 0;
  logic [OVF_W-1:0]  overflow_seen = '0;
  bit                sender_busy   = 1'b0;

  can_tx_frame_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned frames_held();
    return (wr_ptr + SPAN - rd_ptr) % SPAN;
  endfunction

  // advance the shadow queue by one request and work out its result
  function automatic queue_result_t step_queue(ctfq_item_t req);
    queue_result_t     res;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] keep;
    int unsigned       slot;
    res = '0;
    if (req.cmd == CMD_ENQUEUE) begin
      len = (req.frame_length > LEN_MAX) ? LEN_MAX : req.frame_length;
      id  = req.extended_frame ? req.frame_id : ID_W'(req.frame_id[STD_ID_W-1:0]);
      if (frames_held() >= DEPTH) begin
        // full ring: drop the frame and flush everything queued
        if (overflow_seen != OVF_MAX) overflow_seen++;
        rd_ptr = wr_ptr;
      end else begin
        slot = wr_ptr % DEPTH;
        keep = '1;
        if (len < LEN_MAX) keep = (DATA_W'(1) << (8 * len)) - DATA_W'(1);
        ring_id[slot]   = id;
        ring_ext[slot]  = req.extended_frame;
        ring_len[slot]  = len;
        ring_data[slot] = req.frame_data & keep;
        wr_ptr = (wr_ptr + 1) % SPAN;
        res.accepted = 1'b1;
      end
    end else begin
      if (!sender_busy) begin
        if (frames_held() > 0) begin
          slot = rd_ptr % DEPTH;
          res.launch          = 1'b1;
          res.launch_id       = ring_id[slot];
          res.launch_extended = ring_ext[slot];
          res.launch_length   = ring_len[slot];
          res.launch_data     = ring_data[slot];
          rd_ptr = (rd_ptr + 1) % SPAN;
          sender_busy = 1'b1;
        end
      end else if (req.tx_complete) begin
        sender_busy = 1'b0;
        res.clear_complete = 1'b1;
      end
      res.reinit_request = req.bus_off;
    end
    res.overflow_total = overflow_seen;
    res.queued_frames  = QUEUED_W'(frames_held());
    return res;
  endfunction

  function automatic stim_row_t row(logic cmd, logic [ID_W-1:0] id, logic ext,
                                    logic [LEN_W-1:0] len, logic [DATA_W-1:0] data,
                                    logic txc, logic boff, int unsigned reps);
    stim_row_t r;
    r.req.cmd            = cmd;
    r.req.frame_id       = id;
    r.req.extended_frame = ext;
    r.req.frame_length   = len;
    r.req.frame_data     = data;
    r.req.tx_complete    = txc;
    r.req.bus_off        = boff;
    r.reps   = reps;
    r.fixed  = 1'b0;
    r.result = '0;
    return r;
  endfunction

  function automatic stim_row_t with_result(stim_row_t r, queue_result_t res);
    r.fixed  = 1'b1;
    r.result = res;
    return r;
  endfunction

  // result with nothing launched
  function automatic queue_result_t status_only(logic acc, logic clr, logic reinit,
                                                logic [OVF_W-1:0] ovf,
                                                logic [QUEUED_W-1:0] queued);
    queue_result_t res;
    res = '0;
    res.accepted       = acc;
    res.clear_complete = clr;
    res.reinit_request = reinit;
    res.overflow_total = ovf;
    res.queued_frames  = queued;
    return res;
  endfunction

  // random request, enqueue share set by the caller
  function automatic ctfq_item_t random_request(int unsigned enq_pct);
    ctfq_item_t req;
    req.cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_SERVICE;
    case ($urandom_range(0, 9))
      0:       req.frame_id = '1;
      1:       req.frame_id = '0;
      2:       req.frame_id = ID_W'($urandom_range(0, 2047));
      default: req.frame_id = ID_W'($urandom);
    endcase
    req.extended_frame = 1'($urandom_range(0, 1));
    req.frame_length   = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                                     : LEN_W'($urandom_range(0, 8));
    req.frame_data     = {$urandom, $urandom};
    req.tx_complete    = ($urandom_range(0, 99) < 60);
    req.bus_off        = ($urandom_range(0, 9) == 0);
    return req;
  endfunction

  // offer one request in bursts with random gaps, then log its result
  task automatic send_request(ctfq_item_t req, bit fixed, queue_result_t fixed_result);
    queue_result_t predicted;
    int unsigned   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.cmd;
    s_axis_tdata  <= {{(S_TDATA_W - 100){1'b0}}, req.bus_off, req.tx_complete,
                      req.frame_data, req.frame_length, req.extended_frame, req.frame_id};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = step_queue(req);
    pending_results.push_back(fixed ? fixed_result : predicted);
  endtask

  // hold the input back until every outstanding result is in
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR result %0d: %s", result_count, msg);
  endtask

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) flag_error($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  task automatic compare_result(queue_result_t want, queue_result_t got);
    check_field("accepted",        DATA_W'(want.accepted),        DATA_W'(got.accepted));
    check_field("launch",          DATA_W'(want.launch),          DATA_W'(got.launch));
    check_field("launch_id",       DATA_W'(want.launch_id),       DATA_W'(got.launch_id));
    check_field("launch_extended", DATA_W'(want.launch_extended), DATA_W'(got.launch_extended));
    check_field("launch_length",   DATA_W'(want.launch_length),   DATA_W'(got.launch_length));
    check_field("launch_data",     want.launch_data,              got.launch_data);
    check_field("clear_complete",  DATA_W'(want.clear_complete),  DATA_W'(got.clear_complete));
    check_field("reinit_request",  DATA_W'(want.reinit_request),  DATA_W'(got.reinit_request));
    check_field("overflow_total",  DATA_W'(want.overflow_total),  DATA_W'(got.overflow_total));
    check_field("queued_frames",   DATA_W'(want.queued_frames),   DATA_W'(got.queued_frames));
  endtask

  // output stall pattern, in randomly drawn modes
  always @(posedge clk_i) begin : stall_pattern
    if (rx_cycle % 96 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    rx_cycle <= rx_cycle + 1;
    case (rx_mode)
      RX_ALWAYS: m_axis_tready <= 1'b1;
      RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) < 7);
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready <= ((rx_cycle % 16) >= 10);
    endcase
  end

  // collect results and compare with the oldest outstanding one
  always @(posedge clk_i) begin : collect_results
    queue_result_t got;
    queue_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.accepted        = m_axis_tdata[0];
      got.launch          = m_axis_tdata[1];
      got.launch_id       = m_axis_tdata[30:2];
      got.launch_extended = m_axis_tdata[31];
      got.launch_length   = m_axis_tdata[35:32];
      got.launch_data     = m_axis_tdata[99:36];
      got.clear_complete  = m_axis_tdata[100];
      got.reinit_request  = m_axis_tdata[101];
      got.overflow_total  = m_axis_tdata[117:102];
      got.queued_frames   = m_axis_tdata[122:118];
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result %0h", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        compare_result(want, got);
      end
      result_count++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // reset, directed plan, random traffic, drain
  initial begin : stimulus
    stim_row_t     plan[$];
    queue_result_t launch_all;
    int unsigned   enq_pct;
    enq_pct = 50;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first queued frame comes back at full width
    launch_all                 = '0;
    launch_all.launch          = 1'b1;
    launch_all.launch_id       = '1;
    launch_all.launch_extended = 1'b1;
    launch_all.launch_length   = LEN_MAX;
    launch_all.launch_data     = '1;

    // idle sender on an empty queue, bus-off request
    plan.push_back(with_result(row(CMD_SERVICE, '0, 1'b0, '0, '0, 1'b1, 1'b1, 1),
                               status_only(1'b0, 1'b0, 1'b1, '0, '0)));
    plan.push_back(with_result(row(CMD_SERVICE, '1, 1'b1, '1, '1, 1'b0, 1'b0, 1),
                               status_only(1'b0, 1'b0, 1'b0, '0, '0)));
    // extended frame, all ones, length over eight, controller flags ignored
    plan.push_back(with_result(row(CMD_ENQUEUE, '1, 1'b1, '1, '1, 1'b1, 1'b1, 1),
                               status_only(1'b1, 1'b0, 1'b0, '0, 5'd1)));
    plan.push_back(with_result(row(CMD_SERVICE, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1),
                               launch_all));
    // waiting without completion, bus-off on the side
    plan.push_back(with_result(row(CMD_SERVICE, '0, 1'b0, '0, '0, 1'b0, 1'b1, 1),
                               status_only(1'b0, 1'b0, 1'b1, '0, '0)));
    plan.push_back(with_result(row(CMD_SERVICE, '0, 1'b0, '0, '0, 1'b1, 1'b0, 1),
                               status_only(1'b0, 1'b1, 1'b0, '0, '0)));
    // standard id cut, empty frame, full frame, length nine
    plan.push_back(row(CMD_ENQUEUE, '1, 1'b0, 4'd3, 64'h0123_4567_89ab_cdef,
                       1'b0, 1'b0, 1));
    plan.push_back(row(CMD_ENQUEUE, '0, 1'b0, 4'd0, '1, 1'b0, 1'b0, 1));
    plan.push_back(row(CMD_ENQUEUE, 29'h155, 1'b1, 4'd8, 64'ha5a5_5a5a_0ff0_f00f,
                       1'b0, 1'b0, 1));
    plan.push_back(row(CMD_ENQUEUE, 29'h0aaa_aaaa, 1'b1, 4'd9, 64'hfedc_ba98_7654_3210,
                       1'b1, 1'b1, 1));
    plan.push_back(row(CMD_SERVICE, '0, 1'b0, '0, '0, 1'b1, 1'b0, 1));
    plan.push_back(row(CMD_SERVICE, '0, 1'b0, '0, '0, 1'b1, 1'b0, 1));
    plan.push_back(row(CMD_SERVICE, '0, 1'b0, '0, '0, 1'b0, 1'b1, 1));
    plan.push_back(row(CMD_SERVICE, '0, 1'b0, '0, '0, 1'b1, 1'b0, 1));
    // fill the ring, then one more overflows and flushes it
    plan.push_back(row(CMD_ENQUEUE, 29'h1555_5555, 1'b0, 4'd7, 64'h1122_3344_5566_7788,
                       1'b0, 1'b0, 14));
    plan.push_back(with_result(row(CMD_ENQUEUE, 29'h7ff, 1'b0, 4'd1, 64'hff,
                                   1'b0, 1'b0, 1),
                               status_only(1'b0, 1'b0, 1'b0, 16'd1, '0)));
    plan.push_back(with_result(row(CMD_SERVICE, '0, 1'b0, '0, '0, 1'b1, 1'b0, 1),
                               status_only(1'b0, 1'b0, 1'b0, 16'd1, '0)));
    plan.push_back(row(CMD_ENQUEUE, '1, 1'b0, 4'd12, '1, 1'b0, 1'b0, 1));
    plan.push_back(row(CMD_SERVICE, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1));

    foreach (plan[i]) begin
      for (int unsigned k = 0; k < plan[i].reps; k++) begin
        send_request(plan[i].req, plan[i].fixed, plan[i].result);
      end
    end

    // random traffic in phases of different enqueue share
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 4))
          0:       enq_pct = 10;
          1:       enq_pct = 35;
          2:       enq_pct = 50;
          3:       enq_pct = 70;
          default: enq_pct = 92;
        endcase
      end
      if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0) wait_for_results();
      send_request(random_request(enq_pct), 1'b0, '0);
    end

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
